// ----- rtl/qtai_pkg.sv -----
package qtai_pkg;

    // Component format: signed Q14, 16 bits
    localparam int COMP_W = 16;
    localparam int Q_FRAC = 14;

    // One 16x16 product, and a sum of four of them
    localparam int PROD_W = 2 * COMP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int TRUNC_W = SUM_W - Q_FRAC;
    localparam int NUM_PROD = 16;

    // Default depth of the queue between front and back
    localparam int QTAI_QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [1:0] REG_INVERT_X = 2'd0;
    localparam logic [1:0] REG_INVERT_Y = 2'd1;
    localparam logic [1:0] REG_INVERT_Z = 2'd2;

    localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    // Request as it travels from front to back
    typedef struct packed {
        logic signed [COMP_W-1:0] aw;
        logic signed [COMP_W-1:0] ax;
        logic signed [COMP_W-1:0] ay;
        logic signed [COMP_W-1:0] az;
        logic signed [COMP_W-1:0] bw;
        logic signed [COMP_W-1:0] bx;
        logic signed [COMP_W-1:0] by;
        logic signed [COMP_W-1:0] bz;
        logic                     apply;
    } qtai_item_t;

    // Negate with saturation of the most negative code
    function automatic logic signed [COMP_W-1:0] neg_sat(input logic signed [COMP_W-1:0] v);
        logic signed [COMP_W-1:0] r;
        if (v == COMP_MIN)
            r = COMP_MAX;
        else
            r = -v;
        return r;
    endfunction

    // Q28 sum to Q14: truncate toward zero, then saturate to 16 bits
    function automatic logic signed [COMP_W-1:0] q28_to_q14(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0]   adj;
        logic        [TRUNC_W-1:0] t;
        logic signed [COMP_W-1:0]  r;
        adj = s + (s[SUM_W-1] ? SUM_W'((1 << Q_FRAC) - 1) : SUM_W'(0));
        t   = adj[SUM_W-1:Q_FRAC];
        if (!t[TRUNC_W-1] && (|t[TRUNC_W-2:COMP_W-1]))
            r = COMP_MAX;
        else if (t[TRUNC_W-1] && !(&t[TRUNC_W-2:COMP_W-1]))
            r = COMP_MIN;
        else
            r = $signed(t[COMP_W-1:0]);
        return r;
    endfunction

endpackage

// ----- rtl/qtai_front.sv -----
module qtai_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            quat_valid,
    output logic                            quat_stall,
    input  logic signed [15:0]              quat_w,
    input  logic signed [15:0]              quat_x,
    input  logic signed [15:0]              quat_y,
    input  logic signed [15:0]              quat_z,
    input  logic                            tare_request,
    input  logic                            queue_full,
    output logic                            queue_push,
    output qtai_pkg::qtai_item_t            queue_data
);
    import qtai_pkg::*;

    logic signed [COMP_W-1:0] off_w_reg, off_x_reg, off_y_reg, off_z_reg;
    logic signed [COMP_W-1:0] off_w_next, off_x_next, off_y_next, off_z_next;
    logic                     apply_reg, apply_next;

    // Accept whenever the queue has room
    assign quat_stall = queue_full;
    assign queue_push = quat_valid && !queue_full;

    // A tare captures the conjugate; the same request already uses it
    always_comb
    begin
        off_w_next = off_w_reg;
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        off_z_next = off_z_reg;
        apply_next = apply_reg;
        if (queue_push && tare_request)
        begin
            off_w_next = quat_w;
            off_x_next = neg_sat(quat_x);
            off_y_next = neg_sat(quat_y);
            off_z_next = neg_sat(quat_z);
            apply_next = 1'b1;
        end
    end

    always_comb
    begin
        queue_data.aw    = quat_w;
        queue_data.ax    = quat_x;
        queue_data.ay    = quat_y;
        queue_data.az    = quat_z;
        queue_data.bw    = off_w_next;
        queue_data.bx    = off_x_next;
        queue_data.by    = off_y_next;
        queue_data.bz    = off_z_next;
        queue_data.apply = apply_next;
    end

    // Offset is payload: no reset
    always_ff @(posedge clk)
    begin
        off_w_reg <= off_w_next;
        off_x_reg <= off_x_next;
        off_y_reg <= off_y_next;
        off_z_reg <= off_z_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            apply_reg <= 1'b0;
        else
            apply_reg <= apply_next;
    end

endmodule

// ----- rtl/qtai_fifo.sv -----
module qtai_fifo #(
    parameter int DEPTH = qtai_pkg::QTAI_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  qtai_pkg::qtai_item_t push_data,
    output logic                 full,
    input  logic                 pop,
    output qtai_pkg::qtai_item_t pop_data,
    output logic                 not_empty
);
    import qtai_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    qtai_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/qtai_back.sv -----
module qtai_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 queue_not_empty,
    input  qtai_pkg::qtai_item_t queue_data,
    output logic                 queue_pop,
    input  logic                 invert_x,
    input  logic                 invert_y,
    input  logic                 invert_z,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic signed [15:0]   out_w,
    output logic signed [15:0]   out_x,
    output logic signed [15:0]   out_y,
    output logic signed [15:0]   out_z
);
    import qtai_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [NUM_PROD];
    logic signed [PROD_W-1:0] prod_next [NUM_PROD];
    logic signed [COMP_W-1:0] pw_reg, px_reg, py_reg, pz_reg;
    logic                     apply_reg;
    logic                     s1_valid_reg, s1_valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [COMP_W-1:0] ow_reg, ox_reg, oy_reg, oz_reg;
    logic signed [COMP_W-1:0] rw, rx, ry, rz;
    logic signed [SUM_W-1:0]  sw, sx, sy, sz;
    logic                     s1_adv, s2_adv;

    // Pipeline advance: a stage moves when the one after it has room
    assign s2_adv    = !out_valid_reg || !result_stall;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign queue_pop = queue_not_empty && s1_adv;

    always_comb
    begin
        s1_valid_next  = s1_adv ? queue_not_empty : s1_valid_reg;
        out_valid_next = s2_adv ? s1_valid_reg : out_valid_reg;
    end

    // Stage 1: the sixteen partial products of the Hamilton product
    always_comb
    begin
        prod_next[0]  = PROD_W'(queue_data.aw) * PROD_W'(queue_data.bw);
        prod_next[1]  = PROD_W'(queue_data.ax) * PROD_W'(queue_data.bx);
        prod_next[2]  = PROD_W'(queue_data.ay) * PROD_W'(queue_data.by);
        prod_next[3]  = PROD_W'(queue_data.az) * PROD_W'(queue_data.bz);
        prod_next[4]  = PROD_W'(queue_data.aw) * PROD_W'(queue_data.bx);
        prod_next[5]  = PROD_W'(queue_data.ax) * PROD_W'(queue_data.bw);
        prod_next[6]  = PROD_W'(queue_data.ay) * PROD_W'(queue_data.bz);
        prod_next[7]  = PROD_W'(queue_data.az) * PROD_W'(queue_data.by);
        prod_next[8]  = PROD_W'(queue_data.aw) * PROD_W'(queue_data.by);
        prod_next[9]  = PROD_W'(queue_data.ax) * PROD_W'(queue_data.bz);
        prod_next[10] = PROD_W'(queue_data.ay) * PROD_W'(queue_data.bw);
        prod_next[11] = PROD_W'(queue_data.az) * PROD_W'(queue_data.bx);
        prod_next[12] = PROD_W'(queue_data.aw) * PROD_W'(queue_data.bz);
        prod_next[13] = PROD_W'(queue_data.ax) * PROD_W'(queue_data.by);
        prod_next[14] = PROD_W'(queue_data.ay) * PROD_W'(queue_data.bx);
        prod_next[15] = PROD_W'(queue_data.az) * PROD_W'(queue_data.bw);
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            for (int i = 0; i < NUM_PROD; i++)
                prod_reg[i] <= prod_next[i];
            pw_reg    <= queue_data.aw;
            px_reg    <= queue_data.ax;
            py_reg    <= queue_data.ay;
            pz_reg    <= queue_data.az;
            apply_reg <= queue_data.apply;
        end
    end

    // Stage 2: sums, Q28 to Q14, bypass when no offset, axis inversion
    always_comb
    begin
        sw = SUM_W'(prod_reg[0]) - SUM_W'(prod_reg[1])
           - SUM_W'(prod_reg[2]) - SUM_W'(prod_reg[3]);
        sx = SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5])
           + SUM_W'(prod_reg[6]) - SUM_W'(prod_reg[7]);
        sy = SUM_W'(prod_reg[8]) - SUM_W'(prod_reg[9])
           + SUM_W'(prod_reg[10]) + SUM_W'(prod_reg[11]);
        sz = SUM_W'(prod_reg[12]) + SUM_W'(prod_reg[13])
           - SUM_W'(prod_reg[14]) + SUM_W'(prod_reg[15]);
        if (apply_reg)
        begin
            rw = q28_to_q14(sw);
            rx = q28_to_q14(sx);
            ry = q28_to_q14(sy);
            rz = q28_to_q14(sz);
        end
        else
        begin
            rw = pw_reg;
            rx = px_reg;
            ry = py_reg;
            rz = pz_reg;
        end
        if (invert_x)
            rx = neg_sat(rx);
        if (invert_y)
            ry = neg_sat(ry);
        if (invert_z)
            rz = neg_sat(rz);
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            ow_reg <= rw;
            ox_reg <= rx;
            oy_reg <= ry;
            oz_reg <= rz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_w = ow_reg;
    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign out_z = oz_reg;

endmodule

// ----- rtl/quaternion_tare_and_axis_invert.sv -----
// Channel    Handshake                  Payload
// quat       quat_valid / quat_stall    quat_w quat_x quat_y quat_z tare_request
// result     result_valid / result_stall out_w out_x out_y out_z
// config     cfg_write                  cfg_index cfg_data
//
// One request per cycle sustained while result_stall is low; an accepted
// request passes through the queue, the product stage and the output register.
// The product stage multiplies all sixteen 16x16 terms in parallel.
// rst_n clears the apply flag, the inversion bits, the queue and all valid bits.
// quat_stall rises only when the queue is full; a stalled result holds.
module quaternion_tare_and_axis_invert #(
    parameter int QUEUE_DEPTH = qtai_pkg::QTAI_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               quat_valid,
    output logic               quat_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic               tare_request,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] out_w,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [0:0]         cfg_data
);
    import qtai_pkg::*;

    logic       inv_x_reg, inv_y_reg, inv_z_reg;
    logic       queue_full, queue_push, queue_pop, queue_not_empty;
    qtai_item_t push_data, pop_data;

    // Inversion registers; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg <= 1'b0;
            inv_y_reg <= 1'b0;
            inv_z_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INVERT_X: inv_x_reg <= cfg_data[0];
                REG_INVERT_Y: inv_y_reg <= cfg_data[0];
                REG_INVERT_Z: inv_z_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    qtai_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .quat_valid   (quat_valid),
        .quat_stall   (quat_stall),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .tare_request (tare_request),
        .queue_full   (queue_full),
        .queue_push   (queue_push),
        .queue_data   (push_data)
    );

    qtai_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (pop_data),
        .not_empty (queue_not_empty)
    );

    qtai_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_data      (pop_data),
        .queue_pop       (queue_pop),
        .invert_x        (inv_x_reg),
        .invert_y        (inv_y_reg),
        .invert_z        (inv_z_reg),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .out_w           (out_w),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z)
    );

endmodule
